// File: hdl/imu_oc_pkg.sv
// Shared types and constants for the IMU offset calibrate and correct block
`timescale 1ns / 1ps

package imu_oc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int RATE_W      = 17;
    localparam int THRESHOLD_W = 23;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 23'd100;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_SAMPLE   = 2'd0;
    localparam cmd_t CMD_ACC_CAL  = 2'd1;
    localparam cmd_t CMD_GYRO_CAL = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } cal_status_t;

endpackage

// File: hdl/imu_oc_sample_if.sv
// Input sample channel: command and raw six-axis sample
`timescale 1ns / 1ps

interface imu_oc_sample_if
    import imu_oc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    cmd_t                       cmd;
    logic signed [SAMPLE_W-1:0] acc_raw_x;
    logic signed [SAMPLE_W-1:0] acc_raw_y;
    logic signed [SAMPLE_W-1:0] acc_raw_z;
    logic signed [SAMPLE_W-1:0] gyro_raw_x;
    logic signed [SAMPLE_W-1:0] gyro_raw_y;
    logic signed [SAMPLE_W-1:0] gyro_raw_z;

    modport source (
        output valid, cmd, acc_raw_x, acc_raw_y, acc_raw_z,
               gyro_raw_x, gyro_raw_y, gyro_raw_z,
        input  ready
    );

    modport sink (
        input  valid, cmd, acc_raw_x, acc_raw_y, acc_raw_z,
               gyro_raw_x, gyro_raw_y, gyro_raw_z,
        output ready
    );
endinterface

// File: hdl/imu_oc_result_if.sv
// Result channel: corrected sample and calibration status
`timescale 1ns / 1ps

interface imu_oc_result_if
    import imu_oc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] acc_x;
    logic signed [SAMPLE_W-1:0] acc_y;
    logic signed [SAMPLE_W-1:0] acc_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
    logic signed [RATE_W-1:0]   rate_x;
    logic signed [RATE_W-1:0]   rate_y;
    logic signed [RATE_W-1:0]   rate_z;
    logic                       acc_cal_busy;
    logic                       gyro_cal_busy;
    logic                       save_offset;

    modport source (
        output valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
               rate_x, rate_y, rate_z, acc_cal_busy, gyro_cal_busy, save_offset,
        input  ready
    );

    modport sink (
        input  valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
               rate_x, rate_y, rate_z, acc_cal_busy, gyro_cal_busy, save_offset,
        output ready
    );
endinterface

// File: hdl/imu_oc_cfg_if.sv
// Configuration write channel for the motion threshold register
`timescale 1ns / 1ps

interface imu_oc_cfg_if
    import imu_oc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [THRESHOLD_W-1:0] still_threshold;

    modport source (
        output valid, still_threshold,
        input  ready
    );

    modport sink (
        input  valid, still_threshold,
        output ready
    );
endinterface

// File: hdl/imu_oc_cdiv.sv
// Signed divide by a constant, truncating toward zero, by reciprocal multiply
`timescale 1ns / 1ps

module imu_oc_cdiv #(
    parameter int DIVISOR = 200,
    parameter int IN_W    = 24,
    parameter int OUT_W   = 16
) (
    input  logic signed [IN_W-1:0]  num,
    output logic signed [OUT_W-1:0] quot
);

    localparam int L      = $clog2(DIVISOR);
    localparam int SHIFT  = IN_W + L;
    localparam int MULT_W = IN_W + 2;
    localparam int PROD_W = IN_W + MULT_W;
    localparam longint unsigned MULT =
        ((64'd1 << SHIFT) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);

    logic [IN_W-1:0]   mag;
    logic [PROD_W-1:0] prod;
    logic [OUT_W-1:0]  q;

    assign mag  = num[IN_W-1] ? IN_W'(-num) : IN_W'(num);
    assign prod = PROD_W'(mag) * PROD_W'(MULT);
    assign q    = OUT_W'(prod >> SHIFT);
    assign quot = num[IN_W-1] ? OUT_W'(-q) : q;

endmodule

// File: hdl/imu_oc_acc_cal.sv
// Accelerometer offset calibration: sample averaging and offset storage
`timescale 1ns / 1ps

module imu_oc_acc_cal
    import imu_oc_pkg::*;
#(
    parameter int SAMPLES = 200
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  cmd_t                       cmd,
    input  logic signed [SAMPLE_W-1:0] raw [2],
    output logic signed [SAMPLE_W-1:0] offset [2],
    output cal_status_t                status
);

    localparam int L     = $clog2(SAMPLES);
    localparam int SUM_W = L + SAMPLE_W;
    localparam int CNT_W = $clog2(SAMPLES + 1);

    logic                       active_reg;
    logic [CNT_W-1:0]           count_reg;
    logic signed [SAMPLE_W-1:0] offset_reg [2];
    logic signed [SUM_W-1:0]    sum_reg [2];

    logic                       start;
    logic                       active;
    logic                       done;
    logic [CNT_W-1:0]           count_next;
    logic signed [SUM_W-1:0]    sum_next [2];
    logic signed [SAMPLE_W-1:0] quot [2];

    assign start      = (cmd == CMD_ACC_CAL);
    assign active     = start || active_reg;
    assign count_next = (start ? '0 : count_reg) + CNT_W'(1);
    assign done       = active && (count_next == CNT_W'(SAMPLES));

    for (genvar i = 0; i < 2; i++) begin : g_axis
        assign sum_next[i] = (start ? SUM_W'(0) : sum_reg[i]) + SUM_W'(raw[i]);
        assign offset[i]   = start ? SAMPLE_W'(0) : offset_reg[i];

        imu_oc_cdiv #(
            .DIVISOR (SAMPLES),
            .IN_W    (SUM_W),
            .OUT_W   (SAMPLE_W)
        ) u_div (
            .num  (sum_next[i]),
            .quot (quot[i])
        );
    end

    assign status.busy = active && !done;
    assign status.done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            count_reg     <= '0;
            offset_reg[0] <= '0;
            offset_reg[1] <= '0;
        end
        else if (step)
        begin
            active_reg <= active && !done;
            if (active)
            begin
                count_reg <= done ? '0 : count_next;
            end
            for (int i = 0; i < 2; i++)
            begin
                if (done)
                begin
                    offset_reg[i] <= quot[i];
                end
                else
                begin
                    offset_reg[i] <= offset[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && active)
        begin
            sum_reg[0] <= sum_next[0];
            sum_reg[1] <= sum_next[1];
        end
    end

endmodule

// File: hdl/imu_oc_gyro_cal.sv
// Gyroscope offset calibration: averaging with motion check and retry
`timescale 1ns / 1ps

module imu_oc_gyro_cal
    import imu_oc_pkg::*;
#(
    parameter int SAMPLES = 50
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  cmd_t                       cmd,
    input  logic [THRESHOLD_W-1:0]     still_threshold,
    input  logic signed [SAMPLE_W-1:0] raw [3],
    output logic signed [SAMPLE_W-1:0] offset [3],
    output cal_status_t                status
);

    localparam int L     = $clog2(SAMPLES);
    localparam int SUM_W = L + SAMPLE_W;
    localparam int MOT_W = L + SAMPLE_W;
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int CMP_W = (MOT_W > THRESHOLD_W) ? MOT_W : THRESHOLD_W;

    logic                       active_reg;
    logic [CNT_W-1:0]           count_reg;
    logic signed [SAMPLE_W-1:0] offset_reg [3];
    logic signed [SUM_W-1:0]    sum_reg [3];
    logic [MOT_W-1:0]           motion_reg [3];
    logic signed [SAMPLE_W-1:0] prev_reg [3];

    logic                       start;
    logic                       active;
    logic                       done;
    logic                       finish;
    logic [CNT_W-1:0]           count_next;
    logic signed [SUM_W-1:0]    sum_next [3];
    logic [MOT_W-1:0]           motion_next [3];
    logic signed [RATE_W-1:0]   diff [3];
    logic [SAMPLE_W-1:0]        abs_diff [3];
    logic [2:0]                 moved;
    logic signed [SAMPLE_W-1:0] quot [3];

    assign start      = (cmd == CMD_GYRO_CAL);
    assign active     = start || active_reg;
    assign count_next = (start ? '0 : count_reg) + CNT_W'(1);
    assign done       = active && (count_next == CNT_W'(SAMPLES));
    assign finish     = done && (moved == 3'b000);

    for (genvar i = 0; i < 3; i++) begin : g_axis
        assign sum_next[i] = (start ? SUM_W'(0) : sum_reg[i]) + SUM_W'(raw[i]);
        assign diff[i]     = RATE_W'(start ? SAMPLE_W'(0) : prev_reg[i]) - RATE_W'(raw[i]);
        assign abs_diff[i] = diff[i][RATE_W-1] ? SAMPLE_W'(-diff[i]) : SAMPLE_W'(diff[i]);
        assign motion_next[i] = (start ? MOT_W'(0) : motion_reg[i]) + MOT_W'(abs_diff[i]);
        assign moved[i]    = CMP_W'(motion_next[i]) >= CMP_W'(still_threshold);
        assign offset[i]   = offset_reg[i];

        imu_oc_cdiv #(
            .DIVISOR (SAMPLES),
            .IN_W    (SUM_W),
            .OUT_W   (SAMPLE_W)
        ) u_div (
            .num  (sum_next[i]),
            .quot (quot[i])
        );
    end

    assign status.busy = active && !finish;
    assign status.done = finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                offset_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            active_reg <= active && !finish;
            if (active)
            begin
                count_reg <= done ? '0 : count_next;
            end
            if (finish)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    offset_reg[i] <= quot[i];
                end
            end
        end
    end

    // clear sums on every completed attempt so a retry gathers a full set
    always_ff @(posedge clk)
    begin
        if (step && active)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i]    <= done ? SUM_W'(0) : sum_next[i];
                motion_reg[i] <= done ? MOT_W'(0) : motion_next[i];
                prev_reg[i]   <= raw[i];
            end
        end
    end

endmodule

// File: hdl/imu_offset_calibrate_correct_core.sv
// Top level: IMU sample correction with accel and gyro offset calibration
//
//   channel  modport  beat contents
//   -------  -------  ---------------------------------------------------
//   sample   sink     cmd, raw accel x/y/z, raw gyro x/y/z
//   result   source   accel (x/y corrected), raw gyro, gyro rates, cal status
//   cfg      sink     still_threshold (always ready)
//
// One beat per cycle sustained; each result appears the cycle after its sample.
// Throughput is set by the single result register; sample.ready drops only
// while a result is held and result.ready is low.
// Reset clears both offsets, stops calibration and loads still_threshold 100.
// Offset division runs in the completing cycle by constant reciprocal multiply.
`timescale 1ns / 1ps

module imu_offset_calibrate_correct_core
    import imu_oc_pkg::*;
#(
    parameter int ACC_CAL_SAMPLES  = 200,
    parameter int GYRO_CAL_SAMPLES = 50
) (
    input  logic             clk,
    input  logic             rst_n,
    imu_oc_sample_if.sink    sample,
    imu_oc_result_if.source  result,
    imu_oc_cfg_if.sink       cfg
);

    logic [THRESHOLD_W-1:0]     threshold_reg;
    logic                       valid_reg;

    logic signed [SAMPLE_W-1:0] acc_x_reg;
    logic signed [SAMPLE_W-1:0] acc_y_reg;
    logic signed [SAMPLE_W-1:0] acc_z_reg;
    logic signed [SAMPLE_W-1:0] gyro_reg [3];
    logic signed [RATE_W-1:0]   rate_reg [3];
    logic                       acc_busy_reg;
    logic                       gyro_busy_reg;
    logic                       save_reg;

    logic                       step;
    logic signed [SAMPLE_W-1:0] acc_raw [2];
    logic signed [SAMPLE_W-1:0] gyro_raw [3];
    logic signed [SAMPLE_W-1:0] acc_offset [2];
    logic signed [SAMPLE_W-1:0] gyro_bias [3];
    cal_status_t                acc_status;
    cal_status_t                gyro_status;

    assign sample.ready = !valid_reg || result.ready;
    assign step         = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign acc_raw[0]  = sample.acc_raw_x;
    assign acc_raw[1]  = sample.acc_raw_y;
    assign gyro_raw[0] = sample.gyro_raw_x;
    assign gyro_raw[1] = sample.gyro_raw_y;
    assign gyro_raw[2] = sample.gyro_raw_z;

    imu_oc_acc_cal #(
        .SAMPLES (ACC_CAL_SAMPLES)
    ) u_acc_cal (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cmd    (sample.cmd),
        .raw    (acc_raw),
        .offset (acc_offset),
        .status (acc_status)
    );

    imu_oc_gyro_cal #(
        .SAMPLES (GYRO_CAL_SAMPLES)
    ) u_gyro_cal (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .cmd             (sample.cmd),
        .still_threshold (threshold_reg),
        .raw             (gyro_raw),
        .offset          (gyro_bias),
        .status          (gyro_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                threshold_reg <= cfg.still_threshold;
            end
            valid_reg <= step || (valid_reg && !result.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            acc_x_reg     <= acc_raw[0] - acc_offset[0];
            acc_y_reg     <= acc_raw[1] - acc_offset[1];
            acc_z_reg     <= sample.acc_raw_z;
            for (int i = 0; i < 3; i++)
            begin
                gyro_reg[i] <= gyro_raw[i];
                rate_reg[i] <= RATE_W'(gyro_raw[i]) - RATE_W'(gyro_bias[i]);
            end
            acc_busy_reg  <= acc_status.busy;
            gyro_busy_reg <= gyro_status.busy;
            save_reg      <= acc_status.done;
        end
    end

    assign result.valid         = valid_reg;
    assign result.acc_x         = acc_x_reg;
    assign result.acc_y         = acc_y_reg;
    assign result.acc_z         = acc_z_reg;
    assign result.gyro_x        = gyro_reg[0];
    assign result.gyro_y        = gyro_reg[1];
    assign result.gyro_z        = gyro_reg[2];
    assign result.rate_x        = rate_reg[0];
    assign result.rate_y        = rate_reg[1];
    assign result.rate_z        = rate_reg[2];
    assign result.acc_cal_busy  = acc_busy_reg;
    assign result.gyro_cal_busy = gyro_busy_reg;
    assign result.save_offset   = save_reg;

`ifndef NO_ASSERTIONS
    a_save_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.save_offset |-> !result.acc_cal_busy)
        else $error("save_offset with accel calibration still busy");

    a_acc_start_raw: assert property (@(posedge clk) disable iff (!rst_n)
        step && sample.cmd == CMD_ACC_CAL |=>
            result.valid && result.acc_x == $past(sample.acc_raw_x)
            && result.acc_cal_busy && !result.save_offset)
        else $error("accel calibration start beat not passed raw");

    a_gyro_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && sample.cmd == CMD_GYRO_CAL |=> result.valid && result.gyro_cal_busy)
        else $error("gyro calibration start beat not busy");

    a_gyro_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && gyro_status.done |=> result.valid && !result.gyro_cal_busy)
        else $error("gyro calibration done but still busy");
`endif

endmodule

// File: dv/imu_offset_calibrate_correct_core_test.sv
// Self-checking testbench for the IMU offset calibrate and correct core
`timescale 1ns / 1ps

module imu_offset_calibrate_correct_core_test
    import imu_oc_pkg::*;
();

    localparam int   ACC_SAMPLES  = 200;
    localparam int   GYRO_SAMPLES = 50;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam cmd_t CMD_SPARE    = 2'd3;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_MAX = '1;

    typedef struct packed {
        cmd_t                       cmd;
        logic [2:0][SAMPLE_W-1:0]   acc;
        logic [2:0][SAMPLE_W-1:0]   gyro;
    } imu_sample_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] acc_x;
        logic [SAMPLE_W-1:0] acc_y;
        logic [SAMPLE_W-1:0] acc_z;
        logic [SAMPLE_W-1:0] gyro_x;
        logic [SAMPLE_W-1:0] gyro_y;
        logic [SAMPLE_W-1:0] gyro_z;
        logic [RATE_W-1:0]   rate_x;
        logic [RATE_W-1:0]   rate_y;
        logic [RATE_W-1:0]   rate_z;
        logic                acc_cal_busy;
        logic                gyro_cal_busy;
        logic                save_offset;
    } imu_result_t;

    logic clk;
    logic rst_n;

    imu_oc_sample_if sample_ch ();
    imu_oc_result_if result_ch ();
    imu_oc_cfg_if    cfg_ch ();

    imu_offset_calibrate_correct_core #(
        .ACC_CAL_SAMPLES  (ACC_SAMPLES),
        .GYRO_CAL_SAMPLES (GYRO_SAMPLES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    logic [THRESHOLD_W-1:0] still_thr;
    int acc_ofs [3];
    int gyro_ofs [3];
    int acc_total [3];
    int gyro_total [3];
    int motion_total [3];
    int last_gyro [3];
    int acc_n;
    int gyro_n;
    bit acc_busy;
    bit gyro_busy;

    imu_result_t corrected_q [$];
    int errors;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_predictor();
        int i;
        still_thr = THRESHOLD_RESET;
        for (i = 0; i < 3; i++)
        begin
            acc_ofs[i]      = 0;
            gyro_ofs[i]     = 0;
            acc_total[i]    = 0;
            gyro_total[i]   = 0;
            motion_total[i] = 0;
            last_gyro[i]    = 0;
        end
        acc_n     = 0;
        gyro_n    = 0;
        acc_busy  = 1'b0;
        gyro_busy = 1'b0;
    endfunction

    function automatic imu_result_t correct_and_calibrate(imu_sample_t s);
        imu_result_t r;
        int a [3];
        int g [3];
        int d;
        int rate [3];
        int i;
        bit moved;
        bit save;
        save = 1'b0;
        for (i = 0; i < 3; i++)
        begin
            a[i] = $signed(s.acc[i]);
            g[i] = $signed(s.gyro[i]);
        end
        if (s.cmd == CMD_ACC_CAL)
        begin
            acc_busy = 1'b1;
            acc_n    = 0;
            for (i = 0; i < 3; i++)
            begin
                acc_total[i] = 0;
                acc_ofs[i]   = 0;
            end
        end
        else if (s.cmd == CMD_GYRO_CAL)
        begin
            gyro_busy = 1'b1;
            gyro_n    = 0;
            for (i = 0; i < 3; i++)
            begin
                gyro_total[i]   = 0;
                motion_total[i] = 0;
                last_gyro[i]    = 0;
            end
        end

        d = a[0] - acc_ofs[0];
        r.acc_x = d[SAMPLE_W-1:0];
        d = a[1] - acc_ofs[1];
        r.acc_y = d[SAMPLE_W-1:0];
        r.acc_z  = s.acc[2];
        r.gyro_x = s.gyro[0];
        r.gyro_y = s.gyro[1];
        r.gyro_z = s.gyro[2];
        for (i = 0; i < 3; i++)
            rate[i] = g[i] - gyro_ofs[i];
        r.rate_x = rate[0][RATE_W-1:0];
        r.rate_y = rate[1][RATE_W-1:0];
        r.rate_z = rate[2][RATE_W-1:0];

        if (acc_busy)
        begin
            for (i = 0; i < 3; i++)
                acc_total[i] += a[i];
            acc_n++;
            if (acc_n >= ACC_SAMPLES)
            begin
                for (i = 0; i < 3; i++)
                    acc_ofs[i] = acc_total[i] / ACC_SAMPLES;
                acc_n    = 0;
                acc_busy = 1'b0;
                save     = 1'b1;
            end
        end

        if (gyro_busy)
        begin
            for (i = 0; i < 3; i++)
            begin
                d = last_gyro[i] - g[i];
                gyro_total[i]   += g[i];
                motion_total[i] += (d < 0) ? -d : d;
                last_gyro[i]     = g[i];
            end
            gyro_n++;
            if (gyro_n >= GYRO_SAMPLES)
            begin
                moved = 1'b0;
                for (i = 0; i < 3; i++)
                    if (motion_total[i] >= int'(still_thr))
                        moved = 1'b1;
                if (!moved)
                begin
                    for (i = 0; i < 3; i++)
                        gyro_ofs[i] = gyro_total[i] / GYRO_SAMPLES;
                    gyro_busy = 1'b0;
                end
                gyro_n = 0;
                for (i = 0; i < 3; i++)
                begin
                    gyro_total[i]   = 0;
                    motion_total[i] = 0;
                end
            end
        end

        r.acc_cal_busy  = acc_busy;
        r.gyro_cal_busy = gyro_busy;
        r.save_offset   = save;
        return r;
    endfunction

    function automatic imu_sample_t uniform_sample(cmd_t c, logic [SAMPLE_W-1:0] acc_val,
                                                   logic [SAMPLE_W-1:0] gyro_val);
        imu_sample_t s;
        s.cmd  = c;
        s.acc  = {3{acc_val}};
        s.gyro = {3{gyro_val}};
        return s;
    endfunction

    function automatic logic [SAMPLE_W-1:0] near(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic check_field(string name, logic [RATE_W-1:0] want, logic [RATE_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        imu_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (corrected_q.size() == 0)
            begin
                errors++;
                $display("%0t result beat with no expected value: expected none actual acc_x %h",
                         $time, result_ch.acc_x);
            end
            else
            begin
                want = corrected_q.pop_front();
                check_field("acc_x", RATE_W'(want.acc_x), RATE_W'($unsigned(result_ch.acc_x)));
                check_field("acc_y", RATE_W'(want.acc_y), RATE_W'($unsigned(result_ch.acc_y)));
                check_field("acc_z", RATE_W'(want.acc_z), RATE_W'($unsigned(result_ch.acc_z)));
                check_field("gyro_x", RATE_W'(want.gyro_x),
                            RATE_W'($unsigned(result_ch.gyro_x)));
                check_field("gyro_y", RATE_W'(want.gyro_y),
                            RATE_W'($unsigned(result_ch.gyro_y)));
                check_field("gyro_z", RATE_W'(want.gyro_z),
                            RATE_W'($unsigned(result_ch.gyro_z)));
                check_field("rate_x", want.rate_x, $unsigned(result_ch.rate_x));
                check_field("rate_y", want.rate_y, $unsigned(result_ch.rate_y));
                check_field("rate_z", want.rate_z, $unsigned(result_ch.rate_z));
                check_field("acc_cal_busy", RATE_W'(want.acc_cal_busy),
                            RATE_W'(result_ch.acc_cal_busy));
                check_field("gyro_cal_busy", RATE_W'(want.gyro_cal_busy),
                            RATE_W'(result_ch.gyro_cal_busy));
                check_field("save_offset", RATE_W'(want.save_offset),
                            RATE_W'(result_ch.save_offset));
            end
        end
    end

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_sample(imu_sample_t s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.cmd        <= s.cmd;
        sample_ch.acc_raw_x  <= s.acc[0];
        sample_ch.acc_raw_y  <= s.acc[1];
        sample_ch.acc_raw_z  <= s.acc[2];
        sample_ch.gyro_raw_x <= s.gyro[0];
        sample_ch.gyro_raw_y <= s.gyro[1];
        sample_ch.gyro_raw_z <= s.gyro[2];
        do
            @(posedge clk);
        while (!sample_ch.ready);
        corrected_q.push_back(correct_and_calibrate(s));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (corrected_q.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_threshold(logic [THRESHOLD_W-1:0] value);
        wait_drained();
        repeat (2) @(negedge clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.still_threshold <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        still_thr = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(int count);
        imu_sample_t s;
        int acc_center [3];
        int gyro_center [3];
        int gyro_spread;
        int bias_lim;
        int roll;
        int n;
        int i;
        for (i = 0; i < 3; i++)
        begin
            acc_center[i]  = int'($urandom_range(0, 65535)) - 32768;
            gyro_center[i] = 0;
        end
        gyro_spread = 0;
        for (n = 0; n < count; n++)
        begin
            s.cmd = CMD_SAMPLE;
            roll  = $urandom_range(0, 399);
            if (!acc_busy && roll < 20)
                s.cmd = CMD_ACC_CAL;
            else if (acc_busy && roll == 0)
                s.cmd = CMD_ACC_CAL;
            else if (!gyro_busy && roll >= 20 && roll < 60)
                s.cmd = CMD_GYRO_CAL;
            else if (gyro_busy && roll >= 397)
                s.cmd = CMD_GYRO_CAL;
            else if (roll >= 390 && roll < 397)
                s.cmd = CMD_SPARE;
            if (s.cmd == CMD_ACC_CAL)
                for (i = 0; i < 3; i++)
                    acc_center[i] = int'($urandom_range(0, 65535)) - 32768;
            if (s.cmd == CMD_GYRO_CAL)
            begin
                bias_lim    = (still_thr / 3 > 32767) ? 32767 : int'(still_thr / 3);
                gyro_spread = int'($urandom_range(0, (still_thr / 60 > 16384) ? 16384
                                                                              : still_thr / 60));
                for (i = 0; i < 3; i++)
                    gyro_center[i] = int'($urandom_range(0, 2 * bias_lim)) - bias_lim;
            end
            for (i = 0; i < 3; i++)
            begin
                s.acc[i]  = ($urandom_range(0, 99) < 12) ? SAMPLE_W'($urandom)
                                                         : near(acc_center[i], 64);
                s.gyro[i] = ($urandom_range(0, 99) < 1) ? SAMPLE_W'($urandom)
                                                        : near(gyro_center[i], gyro_spread);
            end
            send_sample(s);
            if ($urandom_range(0, 199) == 0)
                wait_drained();
        end
    endtask

    task automatic test_field_extremes();
        send_sample(uniform_sample(CMD_SAMPLE, 16'h7FFF, 16'h7FFF));
        send_sample(uniform_sample(CMD_SAMPLE, 16'h8000, 16'h8000));
        send_sample(uniform_sample(CMD_SAMPLE, 16'h0000, 16'hFFFF));
        send_sample(uniform_sample(CMD_SAMPLE, 16'hFFFF, 16'h0000));
        send_sample(uniform_sample(CMD_SAMPLE, 16'h5555, 16'hAAAA));
        send_sample(uniform_sample(CMD_SAMPLE, 16'hAAAA, 16'h5555));
    endtask

    task automatic test_command_codes();
        send_sample(uniform_sample(CMD_SPARE, 16'h1234, 16'hFEDC));
        send_sample(uniform_sample(CMD_ACC_CAL, 16'h8000, 16'h7FFF));
        send_sample(uniform_sample(CMD_SAMPLE, 16'h7FFF, 16'h8000));
        send_sample(uniform_sample(CMD_ACC_CAL, 16'h0100, 16'h0000));
        send_sample(uniform_sample(CMD_GYRO_CAL, 16'h0100, 16'h7FFF));
        send_sample(uniform_sample(CMD_SAMPLE, 16'h0100, 16'h8000));
        send_sample(uniform_sample(CMD_GYRO_CAL, 16'h0100, 16'h0003));
        send_sample(uniform_sample(CMD_SAMPLE, 16'h0100, 16'h0002));
    endtask

    task automatic test_sender_pause();
        send_sample(uniform_sample(CMD_SAMPLE, 16'h0101, 16'h0001));
        send_sample(uniform_sample(CMD_SAMPLE, 16'h00FF, 16'h0002));
        wait_drained();
        send_sample(uniform_sample(CMD_SAMPLE, 16'h0102, 16'h0001));
    endtask

    task automatic test_random_max_threshold();
        write_threshold(THRESHOLD_MAX);
        run_random(180);
    endtask

    task automatic test_random_zero_threshold();
        send_idle_pct = 52;
        recv_idle_pct = 36;
        write_threshold('0);
        run_random(180);
    endtask

    task automatic test_random_mid_threshold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(THRESHOLD_W'($urandom_range(60, 5000)));
        run_random(120);
        write_threshold(THRESHOLD_RESET);
        run_random(70);
    endtask

    initial
    begin
        errors        = 0;
        cycles        = 0;
        send_idle_pct = 36;
        recv_idle_pct = 52;
        clear_predictor();
        rst_n                  = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.cmd          = CMD_SAMPLE;
        sample_ch.acc_raw_x    = '0;
        sample_ch.acc_raw_y    = '0;
        sample_ch.acc_raw_z    = '0;
        sample_ch.gyro_raw_x   = '0;
        sample_ch.gyro_raw_y   = '0;
        sample_ch.gyro_raw_z   = '0;
        result_ch.ready        = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.still_threshold = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_command_codes();
        test_sender_pause();
        test_random_max_threshold();
        test_random_zero_threshold();
        test_random_mid_threshold();

        // hold until every beat is back, then let the pipe settle
        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
